// ===== hdl/bpc_pkg.sv =====
// shared types, register indexes and constants for the compensation pipeline
package bpc_pkg;

    localparam int RAW_W     = 20;
    localparam int CAL_W     = 48;
    localparam int DIV_STEPS = 64;

    // configuration register indexes
    localparam logic [1:0] REG_TEMP_CAL = 2'd0;
    localparam logic [1:0] REG_PRESS_A  = 2'd1;
    localparam logic [1:0] REG_PRESS_B  = 2'd2;
    localparam logic [1:0] REG_PRESS_C  = 2'd3;

    localparam logic [31:0] TC_MUL          = 32'd5;
    localparam logic [31:0] TC_ROUND        = 32'd128;
    localparam logic [32:0] FINE_OFFSET     = 33'd128000;
    localparam logic [20:0] PRESS_BASE      = 21'd1048576;
    localparam logic [11:0] NUM_SCALE       = 12'd3125;
    localparam logic [63:0] P1_BIAS         = 64'h0000_8000_0000_0000;

    // per-word sideband that rides along the pressure path
    typedef struct packed {
        logic        vld;
        logic        dz;
        logic        neg;
        logic [19:0] rawp;
        logic [31:0] tc;
        logic [31:0] fine;
    } bpc_side_t;

    function automatic logic [63:0] sx16to64(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sx16to32(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

// ===== hdl/bpc_div.sv =====
// pipelined 64-bit signed divider, one quotient bit per stage
module bpc_div
    import bpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  bpc_side_t   in_side,
    input  logic [63:0] in_num,
    input  logic [63:0] in_den,
    output bpc_side_t   out_side,
    output logic [63:0] out_quo
);

    typedef struct packed {
        bpc_side_t   side;
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] den;
    } bpc_div_stage_t;

    bpc_div_stage_t stg_reg [0:DIV_STEPS];
    bpc_div_stage_t stg0_next;

    always_comb begin
        stg0_next      = '0;
        stg0_next.side = in_side;
        stg0_next.side.neg = in_num[63] ^ in_den[63];
        stg0_next.side.dz  = (in_den == 64'd0);
        stg0_next.rem  = 64'd0;
        stg0_next.quo  = in_num[63] ? 64'd0 - in_num : in_num;
        stg0_next.den  = in_den[63] ? 64'd0 - in_den : in_den;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_reg[0].side.vld <= 1'b0;
        end else if (en) begin
            stg_reg[0] <= stg0_next;
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [64:0]    part;
        logic [64:0]    diff;
        logic           ge;
        bpc_div_stage_t stg_next;

        always_comb begin
            part          = {stg_reg[k].rem, stg_reg[k].quo[63]};
            diff          = part - {1'b0, stg_reg[k].den};
            ge            = (part >= {1'b0, stg_reg[k].den});
            stg_next      = stg_reg[k];
            stg_next.rem  = ge ? diff[63:0] : part[63:0];
            stg_next.quo  = {stg_reg[k].quo[62:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stg_reg[k+1].side.vld <= 1'b0;
            end else if (en) begin
                stg_reg[k+1] <= stg_next;
            end
        end
    end

    assign out_side = stg_reg[DIV_STEPS].side;
    assign out_quo  = stg_reg[DIV_STEPS].quo;

endmodule

// ===== hdl/baro_temp_pressure_compensation_top.sv =====
// throughput: one word per cycle while the output is not stalled; the 64-stage divider sets most of the depth
// the whole pipe advances together and holds while the output word is not taken
// reset (synchronous, active low) clears all valid bits and the calibration registers
// a zero pressure divisor gives pressure 0 with m_tuser set
module baro_temp_pressure_compensation_top
    import bpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [47:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // temp reading[19:0], press reading[39:20]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,    // temperature_centi[31:0], fine_temp[63:32],
                                    // pressure_q24_8[95:64]
    output logic        m_tuser     // divisor_zero
);

    logic [47:0] temp_cal_reg, press_a_reg, press_b_reg, press_c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_cal_reg <= '0;
            press_a_reg  <= '0;
            press_b_reg  <= '0;
            press_c_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_TEMP_CAL: temp_cal_reg <= cfg_wdata;
                REG_PRESS_A:  press_a_reg  <= cfg_wdata;
                REG_PRESS_B:  press_b_reg  <= cfg_wdata;
                REG_PRESS_C:  press_c_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [15:0] t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = temp_cal_reg[15:0];
    assign t2 = temp_cal_reg[31:16];
    assign t3 = temp_cal_reg[47:32];
    assign p1 = press_a_reg[15:0];
    assign p2 = press_a_reg[31:16];
    assign p3 = press_a_reg[47:32];
    assign p4 = press_b_reg[15:0];
    assign p5 = press_b_reg[31:16];
    assign p6 = press_b_reg[47:32];
    assign p7 = press_c_reg[15:0];
    assign p8 = press_c_reg[31:16];
    assign p9 = press_c_reg[47:32];

    logic m_tvalid_reg;
    logic en;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // temperature stages
    logic              vld_reg [0:3];
    logic [19:0]       adcp_reg [0:3];
    logic signed [18:0] da_reg, da_next;
    logic signed [17:0] dd_reg, dd_next;
    logic signed [34:0] ma_full;
    logic signed [35:0] sq_full;
    logic signed [31:0] ma_reg, sq_reg, a_reg, a_next, bm_reg, sq_sar;
    logic signed [47:0] bm_full;
    logic signed [31:0] fine_reg, fine_next;
    logic [31:0]        f5, tc_next;

    always_comb begin
        da_next = $signed({2'b00, s_tdata[19:3]}) - $signed({2'b00, t1, 1'b0});
        dd_next = $signed({2'b00, s_tdata[19:4]}) - $signed({2'b00, t1});
        ma_full = da_reg * t2;
        sq_full = dd_reg * dd_reg;
        a_next  = ma_reg >>> 11;
        sq_sar  = sq_reg >>> 12;
        bm_full = sq_sar * t3;
        fine_next = a_reg + (bm_reg >>> 14);
        f5      = fine_reg * TC_MUL + TC_ROUND;
        tc_next = $signed(f5) >>> 8;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) vld_reg[i] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < 4; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            adcp_reg[0] <= s_tdata[39:20];
            for (int i = 1; i < 4; i++) adcp_reg[i] <= adcp_reg[i-1];
            da_reg   <= da_next;
            dd_reg   <= dd_next;
            ma_reg   <= ma_full[31:0];
            sq_reg   <= sq_full[31:0];
            a_reg    <= a_next;
            bm_reg   <= bm_full[31:0];
            fine_reg <= fine_next;
        end
    end

    // pressure stages ahead of the divider
    bpc_side_t side_reg [0:7];
    bpc_side_t side_next;

    logic signed [32:0] x_reg, x_next;
    logic signed [65:0] xx_full;
    logic signed [48:0] xp5_full, xp2_full;
    logic [63:0]        xx_reg;
    logic signed [48:0] xp5_reg [0:2];
    logic signed [48:0] xp2_reg [0:2];
    logic signed [48:0] pp6l_next, pp3l_next, pp6l_reg, pp3l_reg;
    logic [31:0]        pp6h_next, pp3h_next, pp6h_reg, pp3h_reg;
    logic [63:0]        s6_next, s3_next, s6_reg, s3_reg;
    logic [63:0]        y_next, x2_next, y_reg, x2_reg, s3_sar;
    logic [63:0]        x3;
    logic [47:0]        pp1l_next, pp1l_reg;
    logic [31:0]        pp1h_next, pp1h_reg;
    logic [20:0]        pn;
    logic [63:0]        n_next, n_reg;
    logic [63:0]        p1_sum, dv_next, dv_k_reg, dv_l_reg;
    logic [43:0]        nl_next, nl_reg;
    logic [31:0]        nh_next, nh_reg;
    logic [63:0]        num_next, num_reg;

    always_comb begin
        side_next      = '0;
        side_next.vld  = vld_reg[3];
        side_next.rawp = adcp_reg[3];
        side_next.tc   = tc_next;
        side_next.fine = fine_reg;
        x_next    = $signed({fine_reg[31], fine_reg}) - $signed(FINE_OFFSET);
        xx_full   = x_reg * x_reg;
        xp5_full  = x_reg * p5;
        xp2_full  = x_reg * p2;
        pp6l_next = $signed({1'b0, xx_reg[31:0]}) * p6;
        pp3l_next = $signed({1'b0, xx_reg[31:0]}) * p3;
        pp6h_next = xx_reg[63:32] * sx16to32(p6);
        pp3h_next = xx_reg[63:32] * sx16to32(p3);
        s6_next   = {{15{pp6l_reg[48]}}, pp6l_reg} + {pp6h_reg, 32'd0};
        s3_next   = {{15{pp3l_reg[48]}}, pp3l_reg} + {pp3h_reg, 32'd0};
        s3_sar    = $signed(s3_reg) >>> 8;
        y_next    = s6_reg + ({{15{xp5_reg[2][48]}}, xp5_reg[2]} << 17)
                    + (sx16to64(p4) << 35);
        x2_next   = s3_sar + ({{15{xp2_reg[2][48]}}, xp2_reg[2]} << 12);
        x3        = x2_reg + P1_BIAS;
        pp1l_next = x3[31:0] * p1;
        pp1h_next = x3[63:32] * {16'd0, p1};
        pn        = PRESS_BASE - {1'b0, side_reg[4].rawp};
        n_next    = ({43'd0, pn} << 31) - y_reg;
        p1_sum    = {pp1h_reg, 32'd0} + {16'd0, pp1l_reg};
        dv_next   = $signed(p1_sum) >>> 33;
        nl_next   = n_reg[31:0] * NUM_SCALE;
        nh_next   = n_reg[63:32] * {20'd0, NUM_SCALE};
        num_next  = {nh_reg, 32'd0} + {20'd0, nl_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) side_reg[i].vld <= 1'b0;
        end else if (en) begin
            side_reg[0] <= side_next;
            for (int i = 1; i < 8; i++) side_reg[i] <= side_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg      <= x_next;
            xx_reg     <= xx_full[63:0];
            xp5_reg[0] <= xp5_full;
            xp2_reg[0] <= xp2_full;
            for (int i = 1; i < 3; i++) begin
                xp5_reg[i] <= xp5_reg[i-1];
                xp2_reg[i] <= xp2_reg[i-1];
            end
            pp6l_reg <= pp6l_next;
            pp3l_reg <= pp3l_next;
            pp6h_reg <= pp6h_next;
            pp3h_reg <= pp3h_next;
            s6_reg   <= s6_next;
            s3_reg   <= s3_next;
            y_reg    <= y_next;
            x2_reg   <= x2_next;
            pp1l_reg <= pp1l_next;
            pp1h_reg <= pp1h_next;
            n_reg    <= n_next;
            dv_k_reg <= dv_next;
            nl_reg   <= nl_next;
            nh_reg   <= nh_next;
            num_reg  <= num_next;
            dv_l_reg <= dv_k_reg;
        end
    end

    bpc_side_t   div_side;
    logic [63:0] div_quo;

    bpc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_side  (side_reg[7]),
        .in_num   (num_reg),
        .in_den   (dv_l_reg),
        .out_side (div_side),
        .out_quo  (div_quo)
    );

    // correction terms after the divider
    bpc_side_t post_reg [0:5];

    logic [63:0]        p_reg [0:4];
    logic [63:0]        p_next, ph;
    logic [63:0]        ll_next, ll_reg;
    logic [31:0]        lh_next, lh_reg;
    logic signed [48:0] c8l_next, c8l_reg;
    logic [31:0]        c8h_next, c8h_reg;
    logic [63:0]        phph_next, phph_reg, c8_sum, c8_next;
    logic [63:0]        c8_reg [0:2];
    logic signed [48:0] q9l_next, q9l_reg;
    logic [31:0]        q9h_next, q9h_reg;
    logic [63:0]        prod9_next, prod9_reg, c9, s_next, s_reg;
    logic [31:0]        press;

    always_comb begin
        p_next     = div_side.neg ? 64'd0 - div_quo : div_quo;
        ph         = $signed(p_reg[0]) >>> 13;
        ll_next    = ph[31:0] * ph[31:0];
        lh_next    = ph[31:0] * ph[63:32];
        c8l_next   = $signed({1'b0, p_reg[0][31:0]}) * p8;
        c8h_next   = p_reg[0][63:32] * sx16to32(p8);
        // both cross terms of the square are equal
        phph_next  = ll_reg + {lh_reg[30:0], 1'b0, 32'd0};
        c8_sum     = {{15{c8l_reg[48]}}, c8l_reg} + {c8h_reg, 32'd0};
        c8_next    = $signed(c8_sum) >>> 19;
        q9l_next   = $signed({1'b0, phph_reg[31:0]}) * p9;
        q9h_next   = phph_reg[63:32] * sx16to32(p9);
        prod9_next = {{15{q9l_reg[48]}}, q9l_reg} + {q9h_reg, 32'd0};
        c9         = $signed(prod9_reg) >>> 25;
        s_next     = p_reg[4] + c9 + c8_reg[2];
        press      = s_reg[39:8] + {{12{p7[15]}}, p7, 4'd0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) post_reg[i].vld <= 1'b0;
        end else if (en) begin
            post_reg[0] <= div_side;
            for (int i = 1; i < 6; i++) post_reg[i] <= post_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0] <= p_next;
            for (int i = 1; i < 5; i++) p_reg[i] <= p_reg[i-1];
            ll_reg    <= ll_next;
            lh_reg    <= lh_next;
            c8l_reg   <= c8l_next;
            c8h_reg   <= c8h_next;
            phph_reg  <= phph_next;
            c8_reg[0] <= c8_next;
            c8_reg[1] <= c8_reg[0];
            c8_reg[2] <= c8_reg[1];
            q9l_reg   <= q9l_next;
            q9h_reg   <= q9h_next;
            prod9_reg <= prod9_next;
            s_reg     <= s_next;
        end
    end

    // output word register
    logic [95:0] m_tdata_reg;
    logic        m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= post_reg[5].vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {post_reg[5].dz ? 32'd0 : press, post_reg[5].fine, post_reg[5].tc};
            m_tuser_reg <= post_reg[5].dz;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== hdl/bpc_check.sv =====
// port-level checks for the compensation block, bound to the top level
module bpc_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic        m_tuser
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output word valid right after reset");

    a_ready_tracks_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_zero_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[95:64] == 32'd0))
        else $error("pressure not zero on zero divisor");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled output word changed");

endmodule

bind baro_temp_pressure_compensation_top bpc_check u_bpc_check (.*);

// ===== tb/tb_baro_temp_pressure_compensation_top.sv =====
// self-checking bench for the temperature and pressure compensation pipeline
module tb_baro_temp_pressure_compensation_top
    import bpc_pkg::*;
();

    typedef struct {
        logic [31:0] tc;
        logic [31:0] fine;
        logic [31:0] press;
        logic        dz;
    } comp_res_t;

    typedef struct {
        logic [19:0] rawt;
        logic [19:0] rawp;
        logic        known;
        comp_res_t   res;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [47:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic        m_tuser;

    logic [47:0] cal_regs [4];
    comp_res_t   expected_q [$];
    int          mismatches = 0;
    bit          calm = 0;       // no idling in the last part
    bit          hold_off = 0;   // long receiver stall

    baro_temp_pressure_compensation_top u_top (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [31:0] asr32(logic [31:0] v, int n);
        return $unsigned($signed(v) >>> n);
    endfunction

    function automatic logic [63:0] asr64(logic [63:0] v, int n);
        return $unsigned($signed(v) >>> n);
    endfunction

    function automatic logic [63:0] sw64(logic [47:0] r, int k);
        return {{48{r[16*k+15]}}, r[16*k +: 16]};
    endfunction

    function automatic comp_res_t compensate(logic [19:0] rawt, logic [19:0] rawp);
        comp_res_t   r;
        logic [31:0] t1, t2, t3, va, vd, vb, fine;
        logic [63:0] x, y, p, ph, c9, c8, ma, mb, q;
        bit          na, nb;
        t1 = {16'd0, cal_regs[REG_TEMP_CAL][15:0]};
        t2 = sx16to32(cal_regs[REG_TEMP_CAL][31:16]);
        t3 = sx16to32(cal_regs[REG_TEMP_CAL][47:32]);
        va = asr32(({12'd0, rawt} >> 3) - (t1 << 1), 0);
        va = asr32(va * t2, 11);
        vd = ({12'd0, rawt} >> 4) - t1;
        vb = asr32(asr32(vd * vd, 12) * t3, 14);
        fine = va + vb;
        r.fine = fine;
        r.tc = asr32(fine * 32'd5 + 32'd128, 8);
        x = {{32{fine[31]}}, fine} - 64'd128000;
        y = x * x * sw64(cal_regs[REG_PRESS_B], 2);
        y += (x * sw64(cal_regs[REG_PRESS_B], 1)) << 17;
        y += sw64(cal_regs[REG_PRESS_B], 0) << 35;
        x = asr64(x * x * sw64(cal_regs[REG_PRESS_A], 2), 8)
            + ((x * sw64(cal_regs[REG_PRESS_A], 1)) << 12);
        x = asr64(((64'd1 << 47) + x) * {48'd0, cal_regs[REG_PRESS_A][15:0]}, 33);
        r.press = '0;
        r.dz = 1'b1;
        if (x != 0) begin
            p = 64'd1048576 - {44'd0, rawp};
            p = ((p << 31) - y) * 64'd3125;
            na = p[63];
            nb = x[63];
            ma = na ? -p : p;
            mb = nb ? -x : x;
            q = ma / mb;
            p = (na != nb) ? -q : q;
            ph = asr64(p, 13);
            c9 = asr64(sw64(cal_regs[REG_PRESS_C], 2) * ph * ph, 25);
            c8 = asr64(sw64(cal_regs[REG_PRESS_C], 1) * p, 19);
            p = asr64(p + c9 + c8, 8) + (sw64(cal_regs[REG_PRESS_C], 0) << 4);
            r.press = p[31:0];
            r.dz = 1'b0;
        end
        return r;
    endfunction

    task automatic write_cal(logic [1:0] idx, logic [47:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        cal_regs[idx] = val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_word(logic [19:0] rawt, logic [19:0] rawp, bit known,
                             comp_res_t res);
        int        gap;
        comp_res_t exp_res;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {rawp, rawt};
        if (known) exp_res = res;
        else exp_res = compensate(rawt, rawp);
        expected_q.push_back(exp_res);
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    // result side: random stalls plus one long hold-off
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_off = 0;
            end
            if (!calm && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 17);
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        comp_res_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", m_tdata);
            end else begin
                e = expected_q.pop_front();
                if (m_tdata[31:0] !== e.tc || m_tdata[63:32] !== e.fine ||
                    m_tdata[95:64] !== e.press || m_tuser !== e.dz) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp tc=%h fine=%h p=%h dz=%b got %h dz=%b",
                                 e.tc, e.fine, e.press, e.dz, m_tdata, m_tuser);
                end
            end
        end
    end

    initial begin
        stim_row_t   rows [$];
        comp_res_t   zr;
        logic [19:0] rt, rp;
        logic [47:0] tcal [3];
        logic [47:0] pcal [3][3];
        int          k;
        for (int i = 0; i < 4; i++) cal_regs[i] = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // all-zero calibration: divisor is zero and every field reads 0
        zr = '{tc: 32'd0, fine: 32'd0, press: 32'd0, dz: 1'b1};
        rows.push_back('{20'd0, 20'd0, 1'b1, zr});
        rows.push_back('{20'hFFFFF, 20'hFFFFF, 1'b0, zr});
        rows.push_back('{20'hAAAAA, 20'h55555, 1'b0, zr});
        foreach (rows[i]) send_word(rows[i].rawt, rows[i].rawp, rows[i].known, rows[i].res);
        drain();

        // typical factory calibration
        tcal[0] = {16'd50, 16'd26435, 16'd27504};
        pcal[0][0] = {-16'sd2565, -16'sd10685, 16'd36477};
        pcal[0][1] = {16'sd23, 16'sd140, 16'sd3024};
        pcal[0][2] = {16'sd6000, -16'sd7, 16'sd15500};
        // extremes
        tcal[1] = 48'hFFFF_FFFF_FFFF;
        pcal[1][0] = 48'hFFFF_FFFF_FFFF;
        pcal[1][1] = 48'hFFFF_FFFF_FFFF;
        pcal[1][2] = 48'hFFFF_FFFF_FFFF;
        tcal[2] = 48'h7FFF_8000_0000;
        pcal[2][0] = 48'h8000_7FFF_0001;
        pcal[2][1] = 48'h7FFF_8000_7FFF;
        pcal[2][2] = 48'h8000_7FFF_8000;

        for (int ph = 0; ph < 5; ph++) begin
            k = ph < 3 ? ph : 0;
            write_cal(REG_TEMP_CAL, ph < 3 ? tcal[k] : 48'({$urandom, $urandom}));
            for (int j = 0; j < 3; j++)
                write_cal(REG_PRESS_A + 2'(j),
                          ph < 3 ? pcal[k][j] : 48'({$urandom, $urandom}));
            if (ph < 3) begin
                send_word(20'd0, 20'd0, 1'b0, zr);
                send_word(20'hFFFFF, 20'hFFFFF, 1'b0, zr);
                send_word(20'd519888, 20'd415148, 1'b0, zr);
                send_word(20'hFFFFF, 20'd0, 1'b0, zr);
            end
            if (ph == 3) hold_off = 1;
            if (ph == 4) calm = 0;
            for (int i = 0; i < 120; i++) begin
                if (ph == 4 && i == 80) calm = 1;
                if ($urandom_range(0, 3) != 0) begin
                    rt = 20'($urandom_range(400000, 600000));
                    rp = 20'($urandom_range(200000, 700000));
                end else begin
                    rt = 20'($urandom);
                    rp = 20'($urandom);
                end
                send_word(rt, rp, 1'b0, zr);
            end
            drain();
        end

        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
